>>> sv/soa_pkg.sv
`timescale 1ns / 1ps

package soa_pkg;

    localparam int NUM_SLABS = 16;
    localparam int MAX_SLOTS = 64;

    localparam int SLAB_W    = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int INUSE_W   = $clog2(NUM_SLABS + 1);
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NCHUNK    = (MAX_SLOTS + 7) / 8;
    localparam int CH_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_SLOTS = NCHUNK * 8;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 17;
    localparam int CNT_W     = 7;
    localparam int STAMP_W   = 32;
    localparam int DIVC_W    = $clog2(ADDR_W);
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        KIND_UNUSED,
        KIND_EMPTY,
        KIND_PARTIAL,
        KIND_FULL
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OUT_OF_SLABS,
        ST_BAD_ADDR,
        ST_DOUBLE_FREE
    } t_status;

    typedef enum logic [1:0] {
        REG_REGION_BASE,
        REG_SLAB_SIZE,
        REG_OBJECT_SIZE,
        REG_SLOTS_PER_SLAB
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_FIND,
        S_MUL,
        S_ADDR,
        S_FCHK,
        S_FDIV1,
        S_FDIV2
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [SIZE_W-1:0] slab_len;
        logic [SIZE_W-1:0] obj_len;
        logic [CNT_W-1:0]  slots_per_slab;
    } t_cfg;

    typedef struct packed {
        logic    load;
        logic    scan_step;
        logic    pick;
        logic    find_step;
        logic    fill_fail;
        logic    mul;
        logic    alloc_commit;
        logic    div_slab;
        logic    div_slot;
        logic    free_commit;
        logic    rd_scan;
        logic    rd_quot;
        logic    emit;
        t_status emit_status;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic have_partial;
        logic have_empty;
        logic pool_left;
        logic find_hit;
        logic find_last;
        logic div_done;
        logic addr_null;
        logic size_zero;
        logic slab_bad;
        logic slot_bad;
        logic double_free;
    } t_stat;

endpackage

>>> sv/soa_div.sv
`timescale 1ns / 1ps

module soa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [soa_pkg::ADDR_W-1:0]  i_dividend,
    input  logic [soa_pkg::SIZE_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [soa_pkg::ADDR_W-1:0]  o_quot,
    output logic [soa_pkg::SIZE_W-1:0]  o_rem
);

    logic [soa_pkg::ADDR_W-1:0] r_q;
    logic [soa_pkg::SIZE_W-1:0] r_rem;
    logic [soa_pkg::SIZE_W-1:0] r_d;
    logic [soa_pkg::DIVC_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [soa_pkg::SIZE_W:0]   w_trial;
    logic [soa_pkg::SIZE_W:0]   w_diff;
    logic                       w_ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_q[soa_pkg::ADDR_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[soa_pkg::ADDR_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[soa_pkg::SIZE_W-1:0] : w_trial[soa_pkg::SIZE_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == soa_pkg::DIVC_W'(soa_pkg::ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

>>> sv/soa_dp.sv
`timescale 1ns / 1ps

module soa_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  soa_pkg::t_cmd              i_cmd,
    input  soa_pkg::t_cfg              i_cfg,
    input  logic [soa_pkg::ADDR_W-1:0] i_address,
    output soa_pkg::t_stat             o_stat,
    output logic                       o_res_valid,
    output logic [soa_pkg::ADDR_W-1:0] o_res_addr,
    output soa_pkg::t_status           o_res_status
);

    logic [soa_pkg::MAX_SLOTS-1:0] r_bits   [soa_pkg::NUM_SLABS];
    logic [soa_pkg::CNT_W-1:0]     r_cnt    [soa_pkg::NUM_SLABS];
    soa_pkg::t_kind                r_kind   [soa_pkg::NUM_SLABS];
    logic [soa_pkg::STAMP_W-1:0]   r_stamps [soa_pkg::NUM_SLABS];
    logic [soa_pkg::STAMP_W-1:0]   r_stamp_ctr;
    logic [soa_pkg::INUSE_W-1:0]   r_in_use;

    logic [soa_pkg::ADDR_W-1:0]    r_address;
    logic [soa_pkg::SLAB_W-1:0]    r_scan_k;
    logic [soa_pkg::SLAB_W-1:0]    r_sel;
    logic [soa_pkg::SLAB_W-1:0]    r_bp_idx;
    logic [soa_pkg::SLAB_W-1:0]    r_be_idx;
    logic                          r_hp;
    logic                          r_he;
    logic [soa_pkg::STAMP_W-1:0]   r_bp_age;
    logic [soa_pkg::STAMP_W-1:0]   r_be_age;
    logic [soa_pkg::CH_W-1:0]      r_chunk;
    logic [soa_pkg::SLOT_W-1:0]    r_slot;
    logic [soa_pkg::ADDR_W-1:0]    r_p1;
    logic [soa_pkg::ADDR_W-1:0]    r_p2;
    logic                          r_res_valid;
    logic [soa_pkg::ADDR_W-1:0]    r_res_addr;
    soa_pkg::t_status              r_res_status;

    logic [soa_pkg::CNT_W-1:0]     w_n;
    logic [soa_pkg::MAX_SLOTS-1:0] w_mask;
    logic [soa_pkg::SLAB_W-1:0]    w_rd_idx;
    logic [soa_pkg::MAX_SLOTS-1:0] w_rd_bits;
    logic [soa_pkg::CNT_W-1:0]     w_rd_cnt;
    soa_pkg::t_kind                w_rd_kind;
    logic [soa_pkg::STAMP_W-1:0]   w_age;
    logic [soa_pkg::PAD_SLOTS-1:0] w_pad;
    logic [7:0]                    w_byte;
    logic [2:0]                    w_low;
    logic [soa_pkg::CH_W+2:0]      w_slot_full;
    logic [soa_pkg::SLAB_W-1:0]    w_pick_idx;
    logic [soa_pkg::CNT_W-1:0]     w_cnt_inc;
    logic [soa_pkg::CNT_W-1:0]     w_cnt_dec;
    logic [soa_pkg::SLOT_W-1:0]    w_qslot;
    logic [soa_pkg::ADDR_W-1:0]    w_obj_addr;

    logic                          w_div_start;
    logic [soa_pkg::ADDR_W-1:0]    w_div_dividend;
    logic [soa_pkg::SIZE_W-1:0]    w_div_divisor;
    logic                          w_div_done;
    logic [soa_pkg::ADDR_W-1:0]    w_quot;
    logic [soa_pkg::SIZE_W-1:0]    w_rem;

    soa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_div_start    = i_cmd.div_slab | i_cmd.div_slot;
    assign w_div_dividend = i_cmd.div_slab ? (r_address - i_cfg.region_base)
                                           : soa_pkg::ADDR_W'(w_rem);
    assign w_div_divisor  = i_cmd.div_slab ? i_cfg.slab_len : i_cfg.obj_len;

    // effective slot count: clamp to the bitmap width, zero counts as one
    always_comb begin
        if (i_cfg.slots_per_slab > soa_pkg::CNT_W'(soa_pkg::MAX_SLOTS)) begin
            w_n = soa_pkg::CNT_W'(soa_pkg::MAX_SLOTS);
        end else if (i_cfg.slots_per_slab == '0) begin
            w_n = soa_pkg::CNT_W'(1);
        end else begin
            w_n = i_cfg.slots_per_slab;
        end
        for (int i = 0; i < soa_pkg::MAX_SLOTS; i++) begin
            w_mask[i] = soa_pkg::CNT_W'(i) < w_n;
        end
    end

    // single read port on the slab tables
    always_comb begin
        priority if (i_cmd.rd_scan) begin
            w_rd_idx = r_scan_k;
        end else if (i_cmd.rd_quot) begin
            w_rd_idx = w_quot[soa_pkg::SLAB_W-1:0];
        end else begin
            w_rd_idx = r_sel;
        end
    end

    assign w_rd_bits = r_bits[w_rd_idx];
    assign w_rd_cnt  = r_cnt[w_rd_idx];
    assign w_rd_kind = r_kind[w_rd_idx];
    assign w_age     = r_stamp_ctr - r_stamps[w_rd_idx];

    // lowest free slot, one byte of the bitmap per cycle
    always_comb begin
        w_pad  = soa_pkg::PAD_SLOTS'(w_rd_bits & w_mask);
        w_byte = w_pad[{r_chunk, 3'b000} +: 8];
        w_low  = '0;
        for (int j = 7; j >= 0; j--) begin
            if (w_byte[j]) begin
                w_low = 3'(j);
            end
        end
    end

    assign w_slot_full = {r_chunk, w_low};
    assign w_qslot     = w_quot[soa_pkg::SLOT_W-1:0];
    assign w_cnt_inc   = (w_rd_cnt == '1) ? w_rd_cnt : w_rd_cnt + 1'b1;
    assign w_cnt_dec   = (w_rd_cnt != '0) ? w_rd_cnt - 1'b1 : w_rd_cnt;
    assign w_obj_addr  = i_cfg.region_base + r_p1 + r_p2;

    always_comb begin
        priority if (r_hp) begin
            w_pick_idx = r_bp_idx;
        end else if (r_he) begin
            w_pick_idx = r_be_idx;
        end else begin
            w_pick_idx = r_in_use[soa_pkg::SLAB_W-1:0];
        end
    end

    always_comb begin
        o_stat.scan_last    = r_scan_k == soa_pkg::SLAB_W'(soa_pkg::NUM_SLABS - 1);
        o_stat.have_partial = r_hp;
        o_stat.have_empty   = r_he;
        o_stat.pool_left    = r_in_use < soa_pkg::INUSE_W'(soa_pkg::NUM_SLABS);
        o_stat.find_hit     = |w_byte;
        o_stat.find_last    = r_chunk == soa_pkg::CH_W'(soa_pkg::NCHUNK - 1);
        o_stat.div_done     = w_div_done;
        o_stat.addr_null    = r_address == '0;
        o_stat.size_zero    = (i_cfg.slab_len == '0) || (i_cfg.obj_len == '0);
        o_stat.slab_bad     = (w_quot >= soa_pkg::ADDR_W'(r_in_use))
                              || (w_rd_kind == soa_pkg::KIND_UNUSED);
        o_stat.slot_bad     = w_quot >= soa_pkg::ADDR_W'(w_n);
        o_stat.double_free  = w_rd_bits[w_qslot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < soa_pkg::NUM_SLABS; k++) begin
                r_bits[k]   <= '1;
                r_cnt[k]    <= '0;
                r_kind[k]   <= soa_pkg::KIND_UNUSED;
                r_stamps[k] <= '0;
            end
            r_stamp_ctr <= '0;
            r_in_use    <= '0;
            r_res_valid <= 1'b0;
            r_hp        <= 1'b0;
            r_he        <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;

            if (i_cmd.load) begin
                r_address <= i_address;
                r_scan_k  <= '0;
                r_hp      <= 1'b0;
                r_he      <= 1'b0;
            end

            if (i_cmd.scan_step) begin
                if (w_rd_kind == soa_pkg::KIND_PARTIAL && (!r_hp || w_age > r_bp_age)) begin
                    r_hp     <= 1'b1;
                    r_bp_age <= w_age;
                    r_bp_idx <= r_scan_k;
                end
                if (w_rd_kind == soa_pkg::KIND_EMPTY && (!r_he || w_age > r_be_age)) begin
                    r_he     <= 1'b1;
                    r_be_age <= w_age;
                    r_be_idx <= r_scan_k;
                end
                r_scan_k <= r_scan_k + 1'b1;
            end

            if (i_cmd.pick) begin
                r_sel   <= w_pick_idx;
                r_chunk <= '0;
                if (!r_hp) begin
                    r_kind[w_pick_idx]   <= soa_pkg::KIND_PARTIAL;
                    r_stamps[w_pick_idx] <= r_stamp_ctr;
                    r_stamp_ctr          <= r_stamp_ctr + 1'b1;
                    if (!r_he) begin
                        r_bits[w_pick_idx] <= w_mask;
                        r_cnt[w_pick_idx]  <= w_n;
                        r_in_use           <= r_in_use + 1'b1;
                    end
                end
            end

            if (i_cmd.find_step) begin
                r_chunk <= r_chunk + 1'b1;
                if (|w_byte) begin
                    r_slot <= w_slot_full[soa_pkg::SLOT_W-1:0];
                end
            end

            if (i_cmd.fill_fail) begin
                r_cnt[r_sel]  <= '0;
                r_kind[r_sel] <= soa_pkg::KIND_FULL;
            end

            if (i_cmd.mul) begin
                r_p1 <= soa_pkg::ADDR_W'(r_sel) * soa_pkg::ADDR_W'(i_cfg.slab_len);
                r_p2 <= soa_pkg::ADDR_W'(r_slot) * soa_pkg::ADDR_W'(i_cfg.obj_len);
            end

            if (i_cmd.alloc_commit) begin
                r_bits[r_sel][r_slot] <= 1'b0;
                r_cnt[r_sel]          <= w_cnt_dec;
                if (w_cnt_dec == '0) begin
                    r_kind[r_sel] <= soa_pkg::KIND_FULL;
                end
            end

            if (i_cmd.div_slot) begin
                r_sel <= w_quot[soa_pkg::SLAB_W-1:0];
            end

            if (i_cmd.free_commit) begin
                r_bits[r_sel][w_qslot] <= 1'b1;
                r_cnt[r_sel]           <= w_cnt_inc;
                if (w_cnt_inc >= w_n) begin
                    r_kind[r_sel]   <= soa_pkg::KIND_EMPTY;
                    r_stamps[r_sel] <= r_stamp_ctr;
                    r_stamp_ctr     <= r_stamp_ctr + 1'b1;
                end else if (w_rd_kind == soa_pkg::KIND_FULL) begin
                    r_kind[r_sel]   <= soa_pkg::KIND_PARTIAL;
                    r_stamps[r_sel] <= r_stamp_ctr;
                    r_stamp_ctr     <= r_stamp_ctr + 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_res_valid  <= 1'b1;
                r_res_status <= i_cmd.emit_status;
                r_res_addr   <= i_cmd.alloc_commit ? w_obj_addr : '0;
            end
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_res_addr   = r_res_addr;
    assign o_res_status = r_res_status;

endmodule

>>> sv/soa_ctrl.sv
`timescale 1ns / 1ps

module soa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_func,
    input  soa_pkg::t_stat i_stat,
    output soa_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    soa_pkg::t_state r_state;
    soa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= soa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            soa_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_func ? soa_pkg::S_FCHK : soa_pkg::S_SCAN;
                end
            end
            soa_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.rd_scan   = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = soa_pkg::S_PICK;
                end
            end
            soa_pkg::S_PICK: begin
                if (!i_stat.have_partial && !i_stat.have_empty && !i_stat.pool_left) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = soa_pkg::ST_OUT_OF_SLABS;
                    n_state           = soa_pkg::S_IDLE;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_state    = soa_pkg::S_FIND;
                end
            end
            soa_pkg::S_FIND: begin
                o_cmd.find_step = 1'b1;
                if (i_stat.find_hit) begin
                    n_state = soa_pkg::S_MUL;
                end else if (i_stat.find_last) begin
                    o_cmd.fill_fail   = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = soa_pkg::ST_OUT_OF_SLABS;
                    n_state           = soa_pkg::S_IDLE;
                end
            end
            soa_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = soa_pkg::S_ADDR;
            end
            soa_pkg::S_ADDR: begin
                o_cmd.alloc_commit = 1'b1;
                o_cmd.emit         = 1'b1;
                o_cmd.emit_status  = soa_pkg::ST_OK;
                n_state            = soa_pkg::S_IDLE;
            end
            soa_pkg::S_FCHK: begin
                priority if (i_stat.addr_null) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = soa_pkg::ST_OK;
                    n_state           = soa_pkg::S_IDLE;
                end else if (i_stat.size_zero) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = soa_pkg::ST_BAD_ADDR;
                    n_state           = soa_pkg::S_IDLE;
                end else begin
                    o_cmd.div_slab = 1'b1;
                    n_state        = soa_pkg::S_FDIV1;
                end
            end
            soa_pkg::S_FDIV1: begin
                o_cmd.rd_quot = 1'b1;
                if (i_stat.div_done) begin
                    if (i_stat.slab_bad) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = soa_pkg::ST_BAD_ADDR;
                        n_state           = soa_pkg::S_IDLE;
                    end else begin
                        o_cmd.div_slot = 1'b1;
                        n_state        = soa_pkg::S_FDIV2;
                    end
                end
            end
            soa_pkg::S_FDIV2: begin
                if (i_stat.div_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = soa_pkg::S_IDLE;
                    priority if (i_stat.slot_bad) begin
                        o_cmd.emit_status = soa_pkg::ST_BAD_ADDR;
                    end else if (i_stat.double_free) begin
                        o_cmd.emit_status = soa_pkg::ST_DOUBLE_FREE;
                    end else begin
                        o_cmd.free_commit = 1'b1;
                        o_cmd.emit_status = soa_pkg::ST_OK;
                    end
                end
            end
            default: begin
                n_state = soa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != soa_pkg::S_IDLE;

endmodule

>>> sv/slab_object_allocator.sv
`timescale 1ns / 1ps

// Slab object allocator: hands out fixed-size object slots from a pool of
// slabs and takes them back.
// Request channel: drive i_func (0 allocate, 1 free) and i_address (free
// only), and raise start. The beat is taken on the edge where start is high
// and busy is low; busy then stays high until the request has finished.
// Result channel: o_valid pulses for exactly one cycle with o_object_address
// and o_status (ok, out of slabs, bad address, double free). Every request
// gives exactly one result beat. The receiver cannot stall it.
// An allocate scans all slabs once (one per cycle), picks a slab, searches
// its free bitmap a byte per cycle, then forms the address through a
// registered multiply and gives the result beat; when no slab is left it
// answers at the pick step, without a search.
// A free runs two passes of a one-bit-per-cycle divider (slab index, then
// slot index), one for a bad slab index, none for null or zero sizes.
// One request is in flight at a time; the next may be taken at the edge
// that ends its result beat. Configuration sits on an APB-style port, four
// registers at byte offsets 0, 4, 8, 12; write them only while busy is low.
// Reset: synchronous, active low; all slabs unused, every slot free, the
// registers return to base 0, slab 4096 bytes, object 64 bytes, 64 slots.

module slab_object_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [soa_pkg::PADDR_W-1:0]  paddr,
    input  logic [soa_pkg::PDATA_W-1:0]  pwdata,
    output logic [soa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [soa_pkg::ADDR_W-1:0]   i_address,
    output logic                         o_valid,
    output logic [soa_pkg::ADDR_W-1:0]   o_object_address,
    output logic [1:0]                   o_status
);

    soa_pkg::t_cfg    r_cfg;
    soa_pkg::t_cmd    w_cmd;
    soa_pkg::t_stat   w_stat;
    soa_pkg::t_status w_res_status;
    soa_pkg::t_reg    w_reg;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_reg    = soa_pkg::t_reg'(paddr[3:2]);
    assign w_cfg_wr = psel & penable & pwrite;

    // configuration registers, written on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_base    <= '0;
            r_cfg.slab_len       <= soa_pkg::SIZE_W'(4096);
            r_cfg.obj_len        <= soa_pkg::SIZE_W'(64);
            r_cfg.slots_per_slab <= soa_pkg::CNT_W'(64);
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                soa_pkg::REG_REGION_BASE:    r_cfg.region_base    <= pwdata;
                soa_pkg::REG_SLAB_SIZE:      r_cfg.slab_len       <= pwdata[soa_pkg::SIZE_W-1:0];
                soa_pkg::REG_OBJECT_SIZE:    r_cfg.obj_len        <= pwdata[soa_pkg::SIZE_W-1:0];
                soa_pkg::REG_SLOTS_PER_SLAB: r_cfg.slots_per_slab <= pwdata[soa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            soa_pkg::REG_REGION_BASE:    prdata = r_cfg.region_base;
            soa_pkg::REG_SLAB_SIZE:      prdata = soa_pkg::PDATA_W'(r_cfg.slab_len);
            soa_pkg::REG_OBJECT_SIZE:    prdata = soa_pkg::PDATA_W'(r_cfg.obj_len);
            soa_pkg::REG_SLOTS_PER_SLAB: prdata = soa_pkg::PDATA_W'(r_cfg.slots_per_slab);
            default:                     prdata = '0;
        endcase
    end

    soa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    soa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (r_cfg),
        .i_address    (i_address),
        .o_stat       (w_stat),
        .o_res_valid  (o_valid),
        .o_res_addr   (o_object_address),
        .o_res_status (w_res_status)
    );

    assign o_status = w_res_status;

    // an accepted request holds the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request beat taken but block not busy");

    // every request passes through at least one busy state before its result, so result beats never abut
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats on consecutive cycles");

    // failures and frees never carry an address
    a_addr_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != soa_pkg::ST_OK) |-> o_object_address == '0)
        else $error("non-zero address with error status");

    // a result only appears while the block is wrapping up a request
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a request in flight");

endmodule

>>> tb/slab_alloc_checker.sv
`timescale 1ns / 1ps

module slab_alloc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [soa_pkg::PADDR_W-1:0]  paddr,
    input  logic [soa_pkg::PDATA_W-1:0]  pwdata,
    input  logic                         pready,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         i_func,
    input  logic [soa_pkg::ADDR_W-1:0]   i_address,
    input  logic                         o_valid,
    input  logic [soa_pkg::ADDR_W-1:0]   o_object_address,
    input  logic [1:0]                   o_status,
    output int                           o_pending,
    output int                           o_fail_count
);

    typedef struct packed {
        logic [soa_pkg::ADDR_W-1:0] addr;
        soa_pkg::t_status           status;
    } t_reply;

    // shadow registers
    logic [soa_pkg::ADDR_W-1:0] base_r;
    logic [soa_pkg::SIZE_W-1:0] slab_bytes;
    logic [soa_pkg::SIZE_W-1:0] obj_bytes;
    logic [soa_pkg::CNT_W-1:0]  slot_reg;

    // shadow pool
    logic [63:0]                 free_map [soa_pkg::NUM_SLABS];
    logic [soa_pkg::CNT_W-1:0]   free_cnt [soa_pkg::NUM_SLABS];
    soa_pkg::t_kind              list_of  [soa_pkg::NUM_SLABS];
    logic [soa_pkg::STAMP_W-1:0] pushed_at[soa_pkg::NUM_SLABS];
    logic [soa_pkg::STAMP_W-1:0] push_clock;
    int unsigned                 used_slabs;

    t_reply reply_q[$];

    assign o_pending = reply_q.size();

    function automatic int unsigned slot_limit();
        int unsigned n;
        n = slot_reg;
        if (n > soa_pkg::MAX_SLOTS) n = soa_pkg::MAX_SLOTS;
        if (n == 0) n = 1;
        return n;
    endfunction

    function automatic logic [63:0] lane_mask(int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic void push_list(int k, soa_pkg::t_kind kd);
        list_of[k]   = kd;
        pushed_at[k] = push_clock;
        push_clock   = push_clock + 1;
    endfunction

    // oldest by age against the push clock, ties to the lowest index
    function automatic int oldest_in(soa_pkg::t_kind kd);
        int          best;
        logic [31:0] best_age;
        logic [31:0] age;
        best = -1;
        best_age = 0;
        for (int k = 0; k < soa_pkg::NUM_SLABS; k++) begin
            if (list_of[k] == kd) begin
                age = push_clock - pushed_at[k];
                if (best < 0 || age > best_age) begin
                    best = k;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    function automatic t_reply serve_alloc();
        t_reply      r;
        int unsigned n;
        int          sel;
        int          slot;
        logic [63:0] bits;
        logic [31:0] k32;
        r.addr = '0;
        r.status = soa_pkg::ST_OK;
        n = slot_limit();
        sel = oldest_in(soa_pkg::KIND_PARTIAL);
        if (sel < 0) begin
            sel = oldest_in(soa_pkg::KIND_EMPTY);
            if (sel >= 0) begin
                push_list(sel, soa_pkg::KIND_PARTIAL);
            end else if (used_slabs < soa_pkg::NUM_SLABS) begin
                sel = int'(used_slabs);
                used_slabs++;
                free_map[sel] = lane_mask(n);
                free_cnt[sel] = soa_pkg::CNT_W'(n);
                push_list(sel, soa_pkg::KIND_PARTIAL);
            end else begin
                r.status = soa_pkg::ST_OUT_OF_SLABS;
                return r;
            end
        end
        bits = free_map[sel] & lane_mask(n);
        slot = -1;
        for (int i = 63; i >= 0; i--) if (bits[i]) slot = i;
        if (slot < 0) begin
            // slot count shrank under a live slab
            free_cnt[sel] = 0;
            list_of[sel] = soa_pkg::KIND_FULL;
            r.status = soa_pkg::ST_OUT_OF_SLABS;
            return r;
        end
        free_map[sel][slot] = 1'b0;
        if (free_cnt[sel] > 0) free_cnt[sel]--;
        if (free_cnt[sel] == 0) list_of[sel] = soa_pkg::KIND_FULL;
        k32 = sel;
        r.addr = base_r + k32 * 32'(slab_bytes) + 32'(slot) * 32'(obj_bytes);
        return r;
    endfunction

    function automatic soa_pkg::t_status serve_free(logic [31:0] a);
        int unsigned    n;
        logic [31:0]    offset, k, in_slab, slot;
        soa_pkg::t_kind prev;
        n = slot_limit();
        if (a == 0) return soa_pkg::ST_OK;
        if (slab_bytes == 0 || obj_bytes == 0) return soa_pkg::ST_BAD_ADDR;
        offset = a - base_r;
        k = offset / 32'(slab_bytes);
        if (k >= used_slabs || k >= soa_pkg::NUM_SLABS) return soa_pkg::ST_BAD_ADDR;
        if (list_of[k] == soa_pkg::KIND_UNUSED) return soa_pkg::ST_BAD_ADDR;
        in_slab = offset - k * 32'(slab_bytes);
        slot = in_slab / 32'(obj_bytes);
        if (slot >= n) return soa_pkg::ST_BAD_ADDR;
        if (free_map[k][slot]) return soa_pkg::ST_DOUBLE_FREE;
        prev = list_of[k];
        free_map[k][slot] = 1'b1;
        if (free_cnt[k] < 127) free_cnt[k]++;
        if (free_cnt[k] >= n) push_list(k, soa_pkg::KIND_EMPTY);
        else if (prev == soa_pkg::KIND_FULL) push_list(k, soa_pkg::KIND_PARTIAL);
        return soa_pkg::ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_reply r;
        if (!i_rst_n) begin
            base_r = '0;
            slab_bytes = soa_pkg::SIZE_W'(4096);
            obj_bytes = soa_pkg::SIZE_W'(64);
            slot_reg = soa_pkg::CNT_W'(64);
            for (int k = 0; k < soa_pkg::NUM_SLABS; k++) begin
                free_map[k] = '1;
                free_cnt[k] = '0;
                list_of[k] = soa_pkg::KIND_UNUSED;
                pushed_at[k] = '0;
            end
            push_clock = '0;
            used_slabs = 0;
            reply_q.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                unique case (soa_pkg::t_reg'(paddr[3:2]))
                    soa_pkg::REG_REGION_BASE:    base_r = pwdata;
                    soa_pkg::REG_SLAB_SIZE:      slab_bytes = pwdata[soa_pkg::SIZE_W-1:0];
                    soa_pkg::REG_OBJECT_SIZE:    obj_bytes = pwdata[soa_pkg::SIZE_W-1:0];
                    soa_pkg::REG_SLOTS_PER_SLAB: slot_reg = pwdata[soa_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result beat addr=%h status=%0d",
                             $time, o_object_address, o_status);
                    o_fail_count++;
                end else begin
                    r = reply_q[0];
                    reply_q.delete(0);
                    if (o_object_address !== r.addr) begin
                        $display("%0t: object_address expected %h actual %h",
                                 $time, r.addr, o_object_address);
                        o_fail_count++;
                    end
                    if (o_status !== r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, r.status, o_status);
                        o_fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (i_func == 1'b0) begin
                    r = serve_alloc();
                end else begin
                    r.addr = '0;
                    r.status = serve_free(i_address);
                end
                reply_q.insert(reply_q.size(), r);
            end
        end
    end

endmodule

>>> tb/tb_slab_object_allocator.sv
`timescale 1ns / 1ps

module tb_slab_object_allocator;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel, penable, pwrite;
    logic [soa_pkg::PADDR_W-1:0] paddr;
    logic [soa_pkg::PDATA_W-1:0] pwdata;
    logic [soa_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        start;
    logic                        busy;
    logic                        i_func;
    logic [soa_pkg::ADDR_W-1:0]  i_address;
    logic                        o_valid;
    logic [soa_pkg::ADDR_W-1:0]  o_object_address;
    logic [1:0]                  o_status;
    int                          pending;
    int                          fail_count;

    // stimulus-side view of the register settings
    logic [31:0] cur_base;
    int unsigned cur_slab, cur_obj, cur_slots;

    // addresses handed out and not yet returned, and recently returned ones
    logic [31:0] live_q[$];
    logic [31:0] freed_q[$];
    logic        func_q[$];
    int          beats_sent;
    int          allocs_ok;

    slab_object_allocator dut (.*);

    slab_alloc_checker checker_i (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .start, .busy, .i_func, .i_address, .o_valid, .o_object_address,
        .o_status, .o_pending(pending), .o_fail_count(fail_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Harvest allocated addresses so frees can target live objects.
    always @(posedge i_clk) begin
        logic f;
        if (i_rst_n && o_valid && func_q.size() > 0) begin
            f = func_q[0];
            func_q.delete(0);
            if (f == FN_ALLOC && o_status == soa_pkg::ST_OK) begin
                live_q.insert(live_q.size(), o_object_address);
                allocs_ok++;
            end
        end
    end

    // Register write: setup, then access with penable.
    task automatic reg_write(soa_pkg::t_reg idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= soa_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drive one request beat after a random gap; return on the accepting edge.
    task automatic send_req(logic fn, logic [31:0] a);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_func    <= fn;
        i_address <= a;
        do @(posedge i_clk); while (busy);
        func_q.insert(func_q.size(), fn);
        beats_sent++;
    endtask

    // Drop start and hold until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_cfg(logic [31:0] b, int unsigned sl, int unsigned ob,
                           int unsigned ns);
        drain();
        reg_write(soa_pkg::REG_REGION_BASE, b);
        reg_write(soa_pkg::REG_SLAB_SIZE, sl);
        reg_write(soa_pkg::REG_OBJECT_SIZE, ob);
        reg_write(soa_pkg::REG_SLOTS_PER_SLAB, ns);
        cur_base = b;
        cur_slab = sl;
        cur_obj = ob;
        cur_slots = ns;
        live_q.delete();
        freed_q.delete();
    endtask

    // Mostly allocs and frees of live objects; the rest is noise.
    task automatic random_burst(int count, int alloc_pct);
        int          r, idx;
        int unsigned n;
        logic [31:0] a;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct || (r < 85 && live_q.size() == 0)) begin
                send_req(FN_ALLOC, $urandom);
            end else if (r < 85) begin
                idx = $urandom_range(0, live_q.size() - 1);
                a = live_q[idx];
                live_q.delete(idx);
                // sometimes point inside the slot rather than at its start
                if (cur_obj > 1 && $urandom_range(0, 4) == 0)
                    a = a + $urandom_range(1, cur_obj - 1);
                freed_q.insert(freed_q.size(), a);
                if (freed_q.size() > 16) freed_q.delete(0);
                send_req(FN_FREE, a);
            end else if (r < 90 && freed_q.size() > 0) begin
                send_req(FN_FREE, freed_q[$urandom_range(0, freed_q.size() - 1)]);
            end else if (r < 93) begin
                send_req(FN_FREE, 32'd0);
            end else if (r < 97) begin
                send_req(FN_FREE, $urandom);
            end else begin
                // first byte past the last usable slot of some slab
                n = (cur_slots > soa_pkg::MAX_SLOTS) ? soa_pkg::MAX_SLOTS : cur_slots;
                if (n == 0) n = 1;
                a = cur_base + $urandom_range(0, soa_pkg::NUM_SLABS - 1) * cur_slab
                    + n * cur_obj;
                send_req(FN_FREE, a);
            end
            if ($urandom_range(0, 60) == 0) drain();
        end
    endtask

    initial begin
        logic [31:0] rb;
        int unsigned sl, ob, ns;
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        start     = 1'b0;
        i_func    = FN_ALLOC;
        i_address = '0;
        beats_sent = 0;
        allocs_ok = 0;
        cur_base = 0;
        cur_slab = 4096;
        cur_obj = 64;
        cur_slots = 64;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: slab 0 starts at address zero, so its first slot
        // comes back as zero and a later free of it is just null.
        send_req(FN_ALLOC, 32'hFFFF_FFFF);
        send_req(FN_ALLOC, 32'd0);
        send_req(FN_ALLOC, 32'd0);
        send_req(FN_FREE, 32'd64);
        send_req(FN_FREE, 32'd64);              // double free
        send_req(FN_FREE, 32'd0);               // null
        send_req(FN_FREE, 32'd5 * 4096);        // slab never used
        send_req(FN_FREE, 32'd130);             // inside slot two
        send_req(FN_FREE, 32'hFFFF_FFFF);
        send_req(FN_ALLOC, 32'd0);

        // Small slabs at the top of the address space, wrapping past zero.
        set_cfg(32'hFFFF_FF00, 256, 64, 3);
        send_req(FN_ALLOC, 32'd0);
        send_req(FN_FREE, 32'hFFFF_FF00 + 3 * 64);   // past the last slot
        send_req(FN_FREE, 32'hFFFF_FF00 + 256 + 200);
        // zero object size makes every non-null free a bad address
        drain();
        reg_write(soa_pkg::REG_OBJECT_SIZE, 0);
        send_req(FN_FREE, 32'hFFFF_FF40);
        drain();
        reg_write(soa_pkg::REG_SLAB_SIZE, 0);
        reg_write(soa_pkg::REG_OBJECT_SIZE, 64);
        send_req(FN_FREE, 32'hFFFF_FF40);
        send_req(FN_ALLOC, 32'd0);
        drain();
        reg_write(soa_pkg::REG_SLAB_SIZE, 256);
        // one slot per slab: every slab fills on its first allocation
        set_cfg(32'h1000_0000, 64, 64, 1);
        for (int i = 0; i < 6; i++) send_req(FN_ALLOC, 32'd0);

        // Random phases; extremes first, then random settings.
        for (int ph = 0; ph < 10; ph++) begin
            unique case (ph)
                0: begin rb = 32'd0;          sl = 65536; ob = 65536; ns = 1;   end
                1: begin rb = 32'hFFFF_FFFF;  sl = 1;     ob = 1;     ns = 1;   end
                2: begin rb = $urandom;       sl = 4096;  ob = 64;    ns = 64;  end
                3: begin rb = $urandom;       sl = 1024;  ob = 16;    ns = 127; end
                4: begin rb = $urandom;       sl = 96;    ob = 3;     ns = 0;   end
                5: begin rb = $urandom;       sl = 65536; ob = 1024;  ns = 64;  end
                default: begin
                    rb = $urandom;
                    ns = $urandom_range(1, 64);
                    ob = $urandom_range(1, 512);
                    sl = ns * ob;
                    if (sl > 65536) sl = 65536;
                    if ($urandom_range(0, 2) == 0) ns = $urandom_range(0, 127);
                end
            endcase
            set_cfg(rb, sl, ob, ns);
            random_burst(42, (ph % 3 == 0) ? 65 : 50);
            // shrink the slot count under live slabs, then keep going
            if (ph == 6) begin
                drain();
                reg_write(soa_pkg::REG_SLOTS_PER_SLAB, 1);
                cur_slots = 1;
                random_burst(8, 70);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d request beats over reset, directed and random settings;",
                 beats_sent);
        $display("%0d allocations succeeded, frees covered null, bad, double and live.",
                 allocs_ok);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
